### design/wheel_encoder_odometry_top_assert.svh
// Assertion macros shared by the odometry block.
`ifndef WHEEL_ENCODER_ODOMETRY_TOP_ASSERT_SVH
`define WHEEL_ENCODER_ODOMETRY_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define WEO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define WEO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/weo_pkg.sv
`timescale 1ns / 1ps
package weo_pkg;
  localparam int unsigned CntW = 16;
  localparam int unsigned TimW = 32;
  localparam int unsigned DistW = 48;
  localparam int unsigned MagW = CntW + 32;
  // The count magnitude is at most 2^(CntW-1), so the product times 1000 fits here.
  localparam int unsigned NumW = MagW + 9;
  // Speed quotient bits; anything wider saturates.
  localparam int unsigned QuoW = 32;
  localparam int unsigned DenW = TimW + 16;
  localparam int unsigned DivSteps = QuoW;

  localparam logic [2:0] CfgSwap = 3'd0;
  localparam logic [2:0] CfgInvL = 3'd1;
  localparam logic [2:0] CfgInvR = 3'd2;
  localparam logic [2:0] CfgMpc = 3'd3;
  localparam logic [2:0] CfgGain = 3'd4;

  localparam logic OpSample = 1'b0;
  localparam logic OpSet = 1'b1;

  typedef enum logic [2:0] {
    CmdNone, CmdLoad, CmdMul, CmdScale, CmdDivStep, CmdWheel, CmdFilter, CmdFinish
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic op;
    logic baseline_valid;
    logic dt_zero;
  } stat_t;
endpackage

### design/weo_ctrl.sv
`timescale 1ns / 1ps
module weo_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  weo_pkg::stat_t  stat_i,
  output weo_pkg::ctrl_t  ctrl_o,
  output logic            busy_o,
  output logic            done_o
);
  import weo_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StLoad, StMul, StScale, StDiv, StWheel, StFilter, StFinish
  } state_e;

  state_e state_q;
  logic [4:0] cnt_q;

  always_comb begin
    case (state_q)
      StLoad: ctrl_o.cmd = CmdLoad;
      StMul: ctrl_o.cmd = CmdMul;
      StScale: ctrl_o.cmd = CmdScale;
      StDiv: ctrl_o.cmd = CmdDivStep;
      StWheel: ctrl_o.cmd = CmdWheel;
      StFilter: ctrl_o.cmd = CmdFilter;
      StFinish: ctrl_o.cmd = CmdFinish;
      default: ctrl_o.cmd = CmdNone;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StFinish);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
    end else begin
      case (state_q)
        StIdle: if (start_i) state_q <= StLoad;
        StLoad: begin
          if (stat_i.op == OpSet) state_q <= StFilter;
          else if (!stat_i.baseline_valid || stat_i.dt_zero) state_q <= StFinish;
          else state_q <= StMul;
        end
        StMul: state_q <= StScale;
        StScale: begin
          cnt_q <= 5'(DivSteps - 1);
          state_q <= StDiv;
        end
        StDiv: begin
          if (cnt_q == '0) state_q <= StWheel;
          else cnt_q <= cnt_q - 5'd1;
        end
        StWheel: state_q <= StFilter;
        StFilter: state_q <= StFinish;
        StFinish: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

### design/weo_datapath.sv
`timescale 1ns / 1ps
module weo_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  weo_pkg::ctrl_t               ctrl_i,
  output weo_pkg::stat_t               stat_o,
  input  logic                         cfg_swap_i,
  input  logic                         cfg_inv_l_i,
  input  logic                         cfg_inv_r_i,
  input  logic [31:0]                  cfg_mpc_i,
  input  logic [16:0]                  cfg_gain_i,
  input  logic                         operation_i,
  input  logic [15:0]                  left_counter_i,
  input  logic [15:0]                  right_counter_i,
  input  logic [31:0]                  now_ms_i,
  input  logic signed [31:0]           given_left_speed_i,
  input  logic signed [31:0]           given_right_speed_i,
  input  logic signed [47:0]           given_distance_i,
  output logic signed [31:0]           left_speed_o,
  output logic signed [31:0]           right_speed_o,
  output logic signed [47:0]           distance_o,
  output logic                         updated_o
);
  import weo_pkg::*;

  // Latched request.
  logic op_q;
  logic [CntW-1:0] lc_q, rc_q;
  logic [TimW-1:0] now_q;
  logic signed [31:0] gl_q, gr_q;
  logic signed [DistW-1:0] gd_q;
  // Architectural state.
  logic base_q, primed_q;
  logic [CntW-1:0] last_l_q, last_r_q;
  logic [TimW-1:0] last_t_q;
  logic signed [31:0] spl_q, spr_q;
  logic signed [DistW-1:0] dist_q;
  logic upd_q;
  // Work registers; index 0 is the left wheel and index 1 the right wheel.
  logic [TimW-1:0] dt_q;
  logic [CntW-1:0] dlt_q [2];
  logic neg_q [2];
  logic [MagW-1:0] mag_q [2];
  logic sat_q [2];
  logic [DenW-1:0] rem_q [2];
  logic [QuoW-1:0] nlo_q [2];
  logic signed [31:0] wsp_q [2];
  logic signed [DistW-1:0] wd_q [2];

  logic [TimW-1:0] dt_w;
  logic [CntW-1:0] d_a, d_b, dl_w, dr_w;
  logic [DenW-1:0] den;
  logic [CntW-1:0] dabs [2];
  logic [NumW-1:0] num [2];
  logic signed [31:0] in_l, in_r;
  logic signed [DistW:0] dsum, dacc;
  logic [DistW:0] dsum_r;
  logic signed [DistW-1:0] mean;

  assign dt_w = now_q - last_t_q;
  assign d_a = lc_q - last_l_q;
  assign d_b = rc_q - last_r_q;
  assign dl_w = (cfg_swap_i ? d_b : d_a);
  assign dr_w = (cfg_swap_i ? d_a : d_b);
  // Speed is (mag * 1000 / dt) >> 16, so the divisor carries the shift.
  assign den = {dt_q, 16'd0};

  assign stat_o.op = op_q;
  assign stat_o.baseline_valid = base_q;
  assign stat_o.dt_zero = (dt_w == '0);

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      dabs[s] = dlt_q[s][CntW-1] ? CntW'(-dlt_q[s]) : dlt_q[s];
      num[s] = NumW'(mag_q[s]) * NumW'(1000);
    end
  end

  // One restoring division step: shifts the next dividend bit in and the
  // quotient bit out through the same register.
  function automatic logic [DenW+QuoW-1:0] div_step(input logic [DenW-1:0] rem,
                                                    input logic [QuoW-1:0] quo,
                                                    input logic [DenW-1:0] dv);
    logic [DenW:0] t;
    logic ge;
    t = {rem, quo[QuoW-1]};
    ge = (t >= {1'b0, dv});
    if (ge) t = t - {1'b0, dv};
    return {t[DenW-1:0], quo[QuoW-2:0], ge};
  endfunction

  function automatic logic signed [31:0] wheel_speed(input logic [QuoW-1:0] q,
                                                     input logic sat,
                                                     input logic neg);
    logic [31:0] lim, sq;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sq = (sat || q > lim) ? lim : q;
    return neg ? $signed(-sq) : $signed(sq);
  endfunction

  function automatic logic signed [DistW-1:0] wheel_dist(input logic [MagW-1:0] m,
                                                        input logic neg);
    logic signed [DistW-1:0] w;
    w = $signed(DistW'(m[MagW-1:16]));
    return neg ? -w : w;
  endfunction

  // Low-pass filter.
  function automatic logic signed [31:0] lp(input logic signed [31:0] prev,
                                            input logic signed [31:0] inp,
                                            input logic [16:0] g);
    logic [16:0] a;
    logic signed [32:0] diff;
    logic [32:0] mag;
    logic [49:0] prod;
    logic signed [33:0] res;
    a = (g > 17'd65536) ? 17'd65536 : g;
    diff = 33'(inp) - 33'(prev);
    mag = diff[32] ? 33'(-diff) : 33'(diff);
    prod = 50'(mag) * 50'(a);
    res = diff[32] ? 34'(prev) - $signed({1'b0, prod[48:16]})
                   : 34'(prev) + $signed({1'b0, prod[48:16]});
    if (res > 34'sd2147483647) lp = 32'h7FFF_FFFF;
    else if (res < -34'sd2147483648) lp = 32'h8000_0000;
    else lp = res[31:0];
  endfunction

  always_comb begin
    in_l = (op_q == OpSet) ? gl_q : wsp_q[0];
    in_r = (op_q == OpSet) ? gr_q : wsp_q[1];
    dsum = (DistW+1)'(wd_q[0]) + (DistW+1)'(wd_q[1]);
    // Adding the sign bit before halving rounds the mean toward zero.
    dsum_r = dsum + (DistW+1)'(dsum[DistW]);
    mean = $signed(dsum_r[DistW:1]);
    dacc = (DistW+1)'(dist_q) + (DistW+1)'(mean);
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CmdNone: begin
        op_q <= operation_i;
        lc_q <= left_counter_i;
        rc_q <= right_counter_i;
        now_q <= now_ms_i;
        gl_q <= given_left_speed_i;
        gr_q <= given_right_speed_i;
        gd_q <= given_distance_i;
      end
      CmdLoad: begin
        dt_q <= dt_w;
        dlt_q[0] <= cfg_inv_l_i ? CntW'(-dl_w) : dl_w;
        dlt_q[1] <= cfg_inv_r_i ? CntW'(-dr_w) : dr_w;
      end
      CmdMul: begin
        for (int s = 0; s < 2; s++) begin
          neg_q[s] <= dlt_q[s][CntW-1];
          mag_q[s] <= MagW'(dabs[s]) * MagW'(cfg_mpc_i);
        end
      end
      CmdScale: begin
        for (int s = 0; s < 2; s++) begin
          // A quotient that would need more than QuoW bits saturates the speed.
          sat_q[s] <= (num[s] >> (16 + QuoW)) >= NumW'(dt_q);
          rem_q[s] <= DenW'(num[s] >> QuoW);
          nlo_q[s] <= num[s][QuoW-1:0];
        end
      end
      CmdDivStep: begin
        for (int s = 0; s < 2; s++) begin
          {rem_q[s], nlo_q[s]} <= div_step(rem_q[s], nlo_q[s], den);
        end
      end
      CmdWheel: begin
        for (int s = 0; s < 2; s++) begin
          wsp_q[s] <= wheel_speed(nlo_q[s], sat_q[s], neg_q[s]);
          wd_q[s] <= wheel_dist(mag_q[s], neg_q[s]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 1'b0;
      primed_q <= 1'b0;
      last_l_q <= '0;
      last_r_q <= '0;
      last_t_q <= '0;
      spl_q <= '0;
      spr_q <= '0;
      dist_q <= '0;
      upd_q <= 1'b0;
    end else begin
      case (ctrl_i.cmd)
        CmdLoad: begin
          upd_q <= 1'b0;
          if (op_q == OpSample) begin
            if (!base_q) begin
              base_q <= 1'b1;
              last_l_q <= lc_q;
              last_r_q <= rc_q;
              last_t_q <= now_q;
            end else if (dt_w != '0) begin
              last_l_q <= lc_q;
              last_r_q <= rc_q;
              last_t_q <= now_q;
            end
          end
        end
        CmdFilter: begin
          upd_q <= 1'b1;
          primed_q <= 1'b1;
          spl_q <= primed_q ? lp(spl_q, in_l, cfg_gain_i) : in_l;
          spr_q <= primed_q ? lp(spr_q, in_r, cfg_gain_i) : in_r;
          if (op_q == OpSet) begin
            dist_q <= gd_q;
          end else if (dacc[DistW] != dacc[DistW-1]) begin
            // The sum left the 48-bit range: clamp toward its sign.
            dist_q <= dacc[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
          end else begin
            dist_q <= dacc[DistW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign left_speed_o = spl_q;
  assign right_speed_o = spr_q;
  assign distance_o = dist_q;
  assign updated_o = upd_q;
endmodule

### design/wheel_encoder_odometry_top.sv
`timescale 1ns / 1ps
// Wheel encoder odometry: speed and distance from two encoder counters.
// A request on the input channel (in_valid_i/in_ready_o) carries either a
// counter sample or a set command. One result is returned per request on
// the output channel (out_valid_o/out_ready_i) and holds the filtered
// wheel speeds (Q16.16 m/s), the accumulated distance (Q32.16 m) and a flag
// that tells whether the estimate changed.
// A sample that updates the estimate works on both wheels side by side, and
// a 32-step restoring division of the scaled count distance by the elapsed
// time sets the figure. Baseline and zero-interval samples skip the arithmetic,
// and a set request goes straight to the filter. One request is worked on at a time.
// The result waits in an output register; a new request is taken only once
// the receiver has taken it, so a stalled receiver holds the block. Reset
// clears the baseline, the filter and the distance, and loads the
// configuration defaults. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write it only while the block
// is idle, as the block itself does not enforce this.
module wheel_encoder_odometry_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [15:0]        left_counter_i,
  input  logic [15:0]        right_counter_i,
  input  logic [31:0]        now_ms_i,
  input  logic signed [31:0] given_left_speed_i,
  input  logic signed [31:0] given_right_speed_i,
  input  logic signed [47:0] given_distance_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] left_speed_o,
  output logic signed [31:0] right_speed_o,
  output logic signed [47:0] distance_o,
  output logic               updated_o
);
  import weo_pkg::*;
  `include "wheel_encoder_odometry_top_assert.svh"

  logic swap_q, inv_l_q, inv_r_q;
  logic [31:0] mpc_q;
  logic [16:0] gain_q;
  logic busy, done, start, ovalid_q;
  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
      inv_l_q <= 1'b0;
      inv_r_q <= 1'b0;
      mpc_q <= 32'd1317624;
      gain_q <= 17'd19661;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSwap: swap_q <= cfg_data_i[0];
        CfgInvL: inv_l_q <= cfg_data_i[0];
        CfgInvR: inv_r_q <= cfg_data_i[0];
        CfgMpc: mpc_q <= cfg_data_i;
        CfgGain: gain_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy && !ovalid_q;
  assign start = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done) ovalid_q <= 1'b1;
    else if (out_ready_i) ovalid_q <= 1'b0;
  end

  weo_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .ctrl_o(ctrl),
    .busy_o(busy), .done_o(done)
  );

  weo_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_swap_i(swap_q), .cfg_inv_l_i(inv_l_q), .cfg_inv_r_i(inv_r_q),
    .cfg_mpc_i(mpc_q), .cfg_gain_i(gain_q),
    .operation_i, .left_counter_i, .right_counter_i, .now_ms_i,
    .given_left_speed_i, .given_right_speed_i, .given_distance_i,
    .left_speed_o, .right_speed_o, .distance_o, .updated_o
  );

  `WEO_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy, !in_ready_o)
  `WEO_ASSERT_NEXT(a_done_gives_valid, clk_i, rst_ni, done, out_valid_o)
  `WEO_ASSERT_IMP(a_done_while_idle_out, clk_i, rst_ni, done, !out_valid_o)
endmodule

### tb/sv/wheel_encoder_odometry_top_tb.sv
`timescale 1ns / 1ps
module wheel_encoder_odometry_top_tb;
  import weo_pkg::*;

  localparam int WatchdogLimit = 6000;
  localparam int TailCycles = 150;
  localparam longint DistMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint DistMin = -64'sh8000_0000_0000;

  typedef struct {
    logic op;
    logic [15:0] lc;
    logic [15:0] rc;
    logic [31:0] now;
    logic signed [31:0] gl;
    logic signed [31:0] gr;
    logic signed [47:0] gd;
  } odo_req_t;

  typedef struct {
    logic signed [31:0] spd_l;
    logic signed [31:0] spd_r;
    logic signed [47:0] distance;
    logic upd;
  } odo_res_t;

  typedef struct {
    odo_req_t req;
    bit typed;
    odo_res_t res;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic operation_i;
  logic [15:0] left_counter_i, right_counter_i;
  logic [31:0] now_ms_i;
  logic signed [31:0] given_left_speed_i, given_right_speed_i;
  logic signed [47:0] given_distance_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] left_speed_o, right_speed_o;
  logic signed [47:0] distance_o;
  logic updated_o;

  wheel_encoder_odometry_top u_top (.*);

  // Configuration mirror and predicted estimator state.
  bit m_swap, m_inv_l, m_inv_r;
  logic [31:0] m_mpc;
  logic [16:0] m_gain;
  bit est_base, est_primed;
  logic [15:0] est_last_l, est_last_r;
  logic [31:0] est_last_t;
  logic signed [31:0] est_spd_l, est_spd_r;
  longint est_dist;

  odo_res_t pending_q[$];
  int n_err;
  int n_results;
  int idle_cycles;
  bit hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] smooth(logic signed [31:0] prev,
                                               logic signed [31:0] in);
    longint a, diff, magd, stp;
    a = (m_gain > 17'd65536) ? 65536 : longint'(m_gain);
    diff = longint'(in) - longint'(prev);
    magd = (diff < 0) ? -diff : diff;
    stp = (magd * a) >>> 16;
    return sat32(longint'(prev) + ((diff < 0) ? -stp : stp));
  endfunction

  // Distance (Q.16) and speed (Q16.16) of one wheel from its count delta.
  task automatic wheel_calc(input logic [15:0] d_raw, input logic [31:0] dt,
                            output longint wdist, output logic signed [31:0] spd);
    bit neg;
    longint dv;
    bit [63:0] mag, q1, r, sq, lim;
    neg = d_raw[15];
    dv = longint'($signed(d_raw));
    if (neg) dv = -dv;
    mag = 64'(dv) * 64'(m_mpc);
    q1 = mag / 64'(dt);
    r = mag % 64'(dt);
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q1 >= 64'h1_0000_0000_0000) begin
      sq = lim;
    end else begin
      sq = (q1 * 1000 + (r * 1000) / 64'(dt)) >> 16;
      if (sq > lim) sq = lim;
    end
    wdist = neg ? -longint'(mag >> 16) : longint'(mag >> 16);
    spd = neg ? sat32(-longint'(sq)) : sq[31:0];
  endtask

  task automatic predict_odometry(input odo_req_t q, output odo_res_t res);
    logic [31:0] dt;
    logic [15:0] d_a, d_b, dl, dr;
    longint dist_l, dist_r;
    logic signed [31:0] sp_l, sp_r;
    res.upd = 1'b0;
    if (q.op == OpSet) begin
      if (!est_primed) begin
        est_spd_l = q.gl;
        est_spd_r = q.gr;
        est_primed = 1'b1;
      end else begin
        est_spd_l = smooth(est_spd_l, q.gl);
        est_spd_r = smooth(est_spd_r, q.gr);
      end
      est_dist = longint'(q.gd);
      res.upd = 1'b1;
    end else if (!est_base) begin
      est_last_l = q.lc;
      est_last_r = q.rc;
      est_last_t = q.now;
      est_base = 1'b1;
    end else begin
      dt = q.now - est_last_t;
      if (dt != 0) begin
        d_a = q.lc - est_last_l;
        d_b = q.rc - est_last_r;
        dl = m_swap ? d_b : d_a;
        dr = m_swap ? d_a : d_b;
        est_last_l = q.lc;
        est_last_r = q.rc;
        est_last_t = q.now;
        if (m_inv_l) dl = -dl;
        if (m_inv_r) dr = -dr;
        wheel_calc(dl, dt, dist_l, sp_l);
        wheel_calc(dr, dt, dist_r, sp_r);
        if (!est_primed) begin
          est_spd_l = sp_l;
          est_spd_r = sp_r;
          est_primed = 1'b1;
        end else begin
          est_spd_l = smooth(est_spd_l, sp_l);
          est_spd_r = smooth(est_spd_r, sp_r);
        end
        est_dist = est_dist + (dist_l + dist_r) / 2;
        if (est_dist > DistMax) est_dist = DistMax;
        if (est_dist < DistMin) est_dist = DistMin;
        res.upd = 1'b1;
      end
    end
    res.spd_l = est_spd_l;
    res.spd_r = est_spd_r;
    res.distance = est_dist[47:0];
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      CfgSwap: m_swap = val[0];
      CfgInvL: m_inv_l = val[0];
      CfgInvR: m_inv_r = val[0];
      CfgMpc: m_mpc = val;
      CfgGain: m_gain = val[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drives one request and records its expected result once accepted.
  task automatic send_request(input odo_req_t q, input bit typed,
                              input odo_res_t typed_res, input bit may_idle);
    odo_res_t pred;
    if (may_idle && $urandom_range(99) < 10) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= q.op;
    left_counter_i <= q.lc;
    right_counter_i <= q.rc;
    now_ms_i <= q.now;
    given_left_speed_i <= q.gl;
    given_right_speed_i <= q.gr;
    given_distance_i <= q.gd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_odometry(q, pred);
    pending_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off, a stretch with none.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_results >= 200) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (n_results >= 400 && n_results < 600) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk_i) begin
    odo_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        if (n_err < 10) $display("unexpected result: spd_l=%0d spd_r=%0d dist=%0d",
                                 left_speed_o, right_speed_o, distance_o);
        n_err++;
      end else begin
        e = pending_q.pop_front();
        if (e.spd_l !== left_speed_o || e.spd_r !== right_speed_o ||
            e.distance !== distance_o || e.upd !== updated_o) begin
          if (n_err < 10)
            $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     e.spd_l, e.spd_r, e.distance, e.upd,
                     left_speed_o, right_speed_o, distance_o, updated_o);
          n_err++;
        end
      end
    end
  end

  // The run is stopped if no request moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("wheel_encoder_odometry_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    odo_req_t q;
    odo_res_t none;
    logic [15:0] cur_l, cur_r;
    logic [31:0] cur_t;
    int pick;
    int n_sent;

    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = OpSample;
    left_counter_i = '0;
    right_counter_i = '0;
    now_ms_i = '0;
    given_left_speed_i = '0;
    given_right_speed_i = '0;
    given_distance_i = '0;
    n_err = 0;
    n_results = 0;
    idle_cycles = 0;
    hold_done = 1'b0;
    none = '{default: '0};

    m_swap = 0; m_inv_l = 0; m_inv_r = 0;
    m_mpc = 32'd1317624;
    m_gain = 17'd19661;
    est_base = 0; est_primed = 0;
    est_last_l = '0; est_last_r = '0; est_last_t = '0;
    est_spd_l = '0; est_spd_r = '0; est_dist = 0;

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: baseline, zero interval, unprimed set, extremes and wraps.
    q = '{op: OpSample, lc: 16'h0000, rc: 16'h0000, now: 32'd100,
          gl: '0, gr: '0, gd: '0};
    rows.push_back('{q, 1'b1, none});
    q.lc = 16'd5;
    rows.push_back('{q, 1'b1, none});
    q = '{op: OpSet, lc: 16'hFFFF, rc: 16'hFFFF, now: 32'hFFFF_FFFF,
          gl: 32'sh7FFF_FFFF, gr: 32'sh8000_0000, gd: 48'sh7FFF_FFFF_FFFF};
    rows.push_back('{q, 1'b1, '{q.gl, q.gr, q.gd, 1'b1}});
    q.gl = 32'sh8000_0000; q.gr = 32'sh7FFF_FFFF; q.gd = 48'sh8000_0000_0000;
    rows.push_back('{q, 1'b0, none});
    q = '{op: OpSample, lc: 16'hFFFF, rc: 16'h0001, now: 32'd101,
          gl: '0, gr: '0, gd: '0};
    rows.push_back('{q, 1'b0, none});
    q.lc = 16'h7FFF; q.rc = 16'h8000; q.now = 32'hFFFF_FFFF;
    rows.push_back('{q, 1'b0, none});
    q.lc = 16'h8000; q.rc = 16'h7FFF; q.now = 32'h0000_0000;
    rows.push_back('{q, 1'b0, none});
    q.lc = 16'h0000; q.rc = 16'h0000;
    rows.push_back('{q, 1'b0, none});
    q.now = 32'd1;
    rows.push_back('{q, 1'b0, none});
    q = '{op: OpSet, lc: '0, rc: '0, now: '0, gl: '0, gr: '0, gd: '0};
    rows.push_back('{q, 1'b0, none});
    q = '{op: OpSample, lc: 16'd300, rc: 16'hFED4, now: 32'd21,
          gl: '1, gr: '1, gd: '1};
    rows.push_back('{q, 1'b0, none});
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res, 1'b0);
    drain();

    cur_l = 16'h0000; cur_r = 16'h0000; cur_t = 32'd21;
    n_sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          cfg_write(CfgSwap, 32'd1); cfg_write(CfgInvL, 32'd1);
          cfg_write(CfgInvR, 32'd0); cfg_write(CfgMpc, 32'hFFFF_FFFF);
          cfg_write(CfgGain, 32'd0);
        end
        1: begin
          cfg_write(CfgSwap, 32'd0); cfg_write(CfgInvL, 32'd0);
          cfg_write(CfgInvR, 32'd1); cfg_write(CfgMpc, 32'd0);
          cfg_write(CfgGain, 32'h1FFFF);
        end
        2: begin
          cfg_write(CfgSwap, 32'd1); cfg_write(CfgInvL, 32'd1);
          cfg_write(CfgInvR, 32'd1); cfg_write(CfgMpc, 32'd1);
          cfg_write(CfgGain, 32'd65536);
        end
        3: begin
          cfg_write(CfgSwap, 32'd0); cfg_write(CfgInvL, 32'd0);
          cfg_write(CfgInvR, 32'd0); cfg_write(CfgMpc, 32'd1317624);
          cfg_write(CfgGain, 32'd19661);
        end
        default: begin
          cfg_write(CfgSwap, $urandom_range(1)); cfg_write(CfgInvL, $urandom_range(1));
          cfg_write(CfgInvR, $urandom_range(1)); cfg_write(CfgMpc, $urandom);
          cfg_write(CfgGain, $urandom_range(131071));
        end
      endcase
      for (int k = 0; k < 175; k++) begin
        pick = $urandom_range(99);
        q = '{op: OpSample, lc: cur_l, rc: cur_r, now: cur_t,
              gl: $urandom, gr: $urandom, gd: 48'({$urandom, $urandom})};
        if (pick < 10) begin
          q.op = OpSet;
          if ($urandom_range(3) == 0) q.gd = {1'b0, {15{1'b1}}, 32'($urandom_range(255))};
        end else if (pick < 16) begin
          // Noise: arbitrary counters and timestamp.
          q.lc = 16'($urandom); q.rc = 16'($urandom); q.now = $urandom;
        end else if (pick >= 20) begin
          // Well-formed motion: small time step, moderate count deltas.
          q.now = cur_t + $urandom_range(1, 50);
          q.lc = cur_l + 16'($urandom_range(600)) - 16'd300;
          q.rc = cur_r + 16'($urandom_range(600)) - 16'd300;
          if ($urandom_range(19) == 0) q.lc = 16'($urandom);
        end
        if (q.op == OpSample) begin
          cur_l = q.lc; cur_r = q.rc; cur_t = q.now;
        end
        send_request(q, 1'b0, none, !(n_sent >= 400 && n_sent < 600));
        n_sent++;
      end
      drain();
    end

    if (n_err == 0 && pending_q.size() == 0) begin
      $display("wheel_encoder_odometry_top regression: pass");
    end else begin
      $display("wheel_encoder_odometry_top regression: fail");
    end
    $finish;
  end
endmodule
